[rtl/core/four_section_biquad_equalizer_defines.svh]
// Assertion macros used by the equalizer checker.
// No dependencies; take in by `include where assertions are written.
`ifndef FOUR_SECTION_BIQUAD_EQUALIZER_DEFINES_SVH
`define FOUR_SECTION_BIQUAD_EQUALIZER_DEFINES_SVH

// Clocked assertion, off while reset is high.
`define BQEQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define BQEQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/bqeq_pkg.sv]
// Shared types and constants of the biquad equalizer.
// No dependencies; imported by the top level, the checker and the bench.
package bqeq_pkg;

   localparam int SECTIONS_DEF       = 4;
   localparam int SAMPLE_WIDTH_DEF   = 24;
   localparam int COEF_FRAC_BITS_DEF = 27;

   localparam int COEF_W         = 32;
   localparam int GAIN_W         = 16;
   localparam int GAIN_FRAC_BITS = 14;
   localparam int ACC_W          = 64;
   localparam int TAPS           = 5;
   localparam int HIST_PER_SEC   = 4;
   localparam int OPCODE_W       = 2;
   localparam int COEF_IDX_W     = 5;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 16;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_GAIN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYPASS_MODE = 1'd1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_FILTER     = 2'd0,
      OP_COEF_WRITE = 2'd1,
      OP_CLEAR      = 2'd2
   } bqeq_opcode_type;

   typedef enum logic [2:0] {
      TAP_B0,
      TAP_B1,
      TAP_B2,
      TAP_A1,
      TAP_A2,
      TAP_GAIN
   } bqeq_tap_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAP,
      ST_DRAIN,
      ST_ROUND,
      ST_GAIN,
      ST_OUT
   } bqeq_state_type;

endpackage

[rtl/core/bqeq_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bqeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/four_section_biquad_equalizer.sv]
// Biquad equalizer top level: sequencer, shared multiply-accumulate unit, round/saturate.
// Depends on bqeq_pkg and bqeq_ram.
//
// A filter request runs SECTIONS direct-form-I biquads in cascade and then the master
// gain, all on one 32-bit by SAMPLE_WIDTH-bit multiplier feeding a 64-bit accumulator.
// Each section issues its five products, drains the multiply pipeline and then rounds
// and saturates; the gain issues one product, drains and rounds, and only then can the
// next request be taken. In bypass a filter request goes straight to the output state.
// Coefficient writes and history clears complete in the cycle they are accepted. The
// result sits in an output register, so a waiting response does not hold up the next
// request until its result is due.
module four_section_biquad_equalizer #(
   parameter int SECTIONS       = bqeq_pkg::SECTIONS_DEF,
   parameter int SAMPLE_WIDTH   = bqeq_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = bqeq_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [bqeq_pkg::OPCODE_W-1:0]          req_opcode,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample_in,
   input  logic [bqeq_pkg::COEF_IDX_W-1:0]        req_coef_index,
   input  logic signed [bqeq_pkg::COEF_W-1:0]     req_coef_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_sample_out,
   input  logic                                   csr_we,
   input  logic [bqeq_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bqeq_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import bqeq_pkg::*;

   localparam int NCOEF     = TAPS * SECTIONS;
   localparam int CA_W      = $clog2(NCOEF);
   localparam int SEC_W     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int ROW_W     = HIST_PER_SEC * SAMPLE_WIDTH;
   localparam int IDX_CMP_W = (CA_W > COEF_IDX_W) ? CA_W : COEF_IDX_W;
   localparam int PROD_W    = COEF_W + SAMPLE_WIDTH;

   localparam logic [IDX_CMP_W-1:0] NCOEF_LIM = IDX_CMP_W'(NCOEF);
   localparam logic [SEC_W-1:0]     SEC_LAST  = SEC_W'(SECTIONS - 1);
   localparam logic [ACC_W-1:0]     COEF_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic [ACC_W-1:0]     GAIN_HALF = ACC_W'(1) << (GAIN_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI =
      $signed((ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1));
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   // sequencer and configuration
   bqeq_state_type state_ff, state_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic              bypass_ff, bypass_in;
   logic [NCOEF-1:0]    coef_vld_ff, coef_vld_in;
   logic [SECTIONS-1:0] hist_vld_ff, hist_vld_in;
   logic              coef_rvld_ff, coef_rvld_in;
   logic              hist_rvld_ff, hist_rvld_in;
   logic [CA_W-1:0]   coef_addr_ff, coef_addr_in;
   logic [SEC_W-1:0]  sec_ff, sec_in;
   bqeq_tap_type      tap_ff, tap_in;
   logic              gain_phase_ff, gain_phase_in;

   // multiply-accumulate pipeline
   logic              b_vld_ff, b_vld_in;
   bqeq_tap_type      b_tap_ff, b_tap_in;
   logic              c_vld_ff, c_vld_in;
   logic              c_neg_ff, c_neg_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // section operands
   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic signed [SAMPLE_WIDTH-1:0] hx1_ff, hx1_in, hx2_ff, hx2_in;
   logic signed [SAMPLE_WIDTH-1:0] hy1_ff, hy1_in, hy2_ff, hy2_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   // control from the sequencer
   logic             start;
   logic             byp_load;
   logic             issue;
   bqeq_tap_type     issue_tap;
   logic             coef_rd_en;
   logic             coef_wr_en;
   logic             capture_row;
   logic             hist_rd_en;
   logic [SEC_W-1:0] hist_rd_addr;
   logic             hist_wr_en;
   logic             hist_clr;
   logic             acc_clr;
   logic             round_step;
   logic             out_load;

   // datapath
   logic [IDX_CMP_W-1:0]           idx_ext;
   logic                           idx_ok;
   logic [CA_W-1:0]                coef_wr_addr;
   logic [COEF_W-1:0]              coef_rdata;
   logic [ROW_W-1:0]               hist_rdata;
   logic [ROW_W-1:0]               hist_wdata;
   logic signed [COEF_W-1:0]       coef_opnd;
   logic signed [SAMPLE_WIDTH-1:0] data_opnd;
   logic signed [PROD_W-1:0]       mult_full;
   logic signed [ACC_W-1:0]        rnd_sum;
   logic signed [ACC_W-1:0]        rnd_shr;
   logic signed [ACC_W-1:0]        rnd_sat;
   logic signed [SAMPLE_WIDTH-1:0] y_sat;

   assign idx_ext      = IDX_CMP_W'(req_coef_index);
   assign idx_ok       = idx_ext < NCOEF_LIM;
   assign coef_wr_addr = idx_ext[CA_W-1:0];

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_opcode == OP_FILTER) begin
               state_in = bypass_ff ? ST_OUT : ST_TAP;
            end
         end
         ST_TAP: begin
            if (tap_ff == TAP_A2) begin
               state_in = ST_DRAIN;
            end
         end
         ST_GAIN: state_in = ST_DRAIN;
         ST_DRAIN: begin
            // last product enters the accumulator this cycle
            if (!b_vld_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (gain_phase_ff) begin
               state_in = ST_OUT;
            end else if (sec_ff == SEC_LAST) begin
               state_in = ST_GAIN;
            end else begin
               state_in = ST_TAP;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- sequencer outputs
   always_comb begin
      req_ready    = 1'b0;
      start        = 1'b0;
      byp_load     = 1'b0;
      issue        = 1'b0;
      issue_tap    = TAP_B0;
      coef_rd_en   = 1'b0;
      coef_wr_en   = 1'b0;
      capture_row  = 1'b0;
      hist_rd_en   = 1'b0;
      hist_rd_addr = sec_ff + SEC_W'(1);
      hist_wr_en   = 1'b0;
      hist_clr     = 1'b0;
      round_step   = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            hist_rd_addr = '0;
            if (req_valid) begin
               case (req_opcode)
                  OP_FILTER: begin
                     if (bypass_ff) begin
                        byp_load = 1'b1;
                     end else begin
                        start      = 1'b1;
                        hist_rd_en = 1'b1;
                     end
                  end
                  OP_COEF_WRITE: coef_wr_en = idx_ok;
                  OP_CLEAR:      hist_clr   = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_TAP: begin
            issue       = 1'b1;
            issue_tap   = tap_ff;
            coef_rd_en  = 1'b1;
            capture_row = (tap_ff == TAP_B0);
         end
         ST_GAIN: begin
            issue     = 1'b1;
            issue_tap = TAP_GAIN;
         end
         ST_ROUND: begin
            round_step = 1'b1;
            if (!gain_phase_ff) begin
               hist_wr_en = 1'b1;
               // fetch the next section's history while this one is written back
               hist_rd_en = (sec_ff != SEC_LAST);
            end
         end
         ST_OUT: out_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign acc_clr = start | round_step;

   // ---------------------------------------------------------------- storage
   bqeq_ram #(
      .WIDTH (COEF_W),
      .DEPTH (NCOEF)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (req_coef_value),
      .rd_en   (coef_rd_en),
      .rd_addr (coef_addr_ff),
      .rd_data (coef_rdata)
   );

   // row layout, low to high: x1, x2, y1, y2
   assign hist_wdata = {hy1_ff, y_sat, hx1_ff, x_ff};

   bqeq_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SECTIONS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (sec_ff),
      .wr_data (hist_wdata),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rdata)
   );

   // ---------------------------------------------------------------- datapath
   always_comb begin
      if (b_tap_ff == TAP_GAIN) begin
         coef_opnd = $signed(COEF_W'(gain_ff));
      end else if (coef_rvld_ff) begin
         coef_opnd = $signed(coef_rdata);
      end else begin
         coef_opnd = '0;
      end
      case (b_tap_ff)
         TAP_B1:  data_opnd = hx1_ff;
         TAP_B2:  data_opnd = hx2_ff;
         TAP_A1:  data_opnd = hy1_ff;
         TAP_A2:  data_opnd = hy2_ff;
         default: data_opnd = x_ff;
      endcase
   end

   assign mult_full = coef_opnd * data_opnd;

   // round half up, arithmetic shift, saturate to the sample range
   always_comb begin
      rnd_sum = $signed(acc_ff + (gain_phase_ff ? GAIN_HALF : COEF_HALF));
      if (gain_phase_ff) begin
         rnd_shr = rnd_sum >>> GAIN_FRAC_BITS;
      end else begin
         rnd_shr = rnd_sum >>> COEF_FRAC_BITS;
      end
      if (rnd_shr > SAT_HI) begin
         rnd_sat = SAT_HI;
      end else if (rnd_shr < SAT_LO) begin
         rnd_sat = SAT_LO;
      end else begin
         rnd_sat = rnd_shr;
      end
      y_sat = $signed(rnd_sat[SAMPLE_WIDTH-1:0]);
   end

   // ---------------------------------------------------------------- next values
   always_comb begin
      gain_in       = gain_ff;
      bypass_in     = bypass_ff;
      coef_vld_in   = coef_vld_ff;
      hist_vld_in   = hist_vld_ff;
      coef_rvld_in  = coef_rvld_ff;
      hist_rvld_in  = hist_rvld_ff;
      coef_addr_in  = coef_addr_ff;
      sec_in        = sec_ff;
      tap_in        = tap_ff;
      gain_phase_in = gain_phase_ff;
      x_in          = x_ff;
      hx1_in        = hx1_ff;
      hx2_in        = hx2_ff;
      hy1_in        = hy1_ff;
      hy2_in        = hy2_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_MASTER_GAIN: gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_BYPASS_MODE: bypass_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (coef_wr_en) begin
         coef_vld_in[coef_wr_addr] = 1'b1;
      end
      if (coef_rd_en) begin
         coef_rvld_in = coef_vld_ff[coef_addr_ff];
         coef_addr_in = coef_addr_ff + CA_W'(1);
      end

      if (hist_clr) begin
         hist_vld_in = '0;
      end else if (hist_wr_en) begin
         hist_vld_in[sec_ff] = 1'b1;
      end
      if (hist_rd_en) begin
         hist_rvld_in = hist_vld_ff[hist_rd_addr];
      end

      if (capture_row) begin
         if (hist_rvld_ff) begin
            hx1_in = $signed(hist_rdata[0*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
            hx2_in = $signed(hist_rdata[1*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
            hy1_in = $signed(hist_rdata[2*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
            hy2_in = $signed(hist_rdata[3*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
         end else begin
            hx1_in = '0;
            hx2_in = '0;
            hy1_in = '0;
            hy2_in = '0;
         end
      end

      if (start) begin
         coef_addr_in  = '0;
         sec_in        = '0;
         tap_in        = TAP_B0;
         gain_phase_in = 1'b0;
      end else if (state_ff == ST_TAP) begin
         case (tap_ff)
            TAP_B0:  tap_in = TAP_B1;
            TAP_B1:  tap_in = TAP_B2;
            TAP_B2:  tap_in = TAP_A1;
            TAP_A1:  tap_in = TAP_A2;
            default: tap_in = TAP_B0;
         endcase
      end else if (round_step && !gain_phase_ff) begin
         tap_in = TAP_B0;
         sec_in = sec_ff + SEC_W'(1);
         if (sec_ff == SEC_LAST) begin
            gain_phase_in = 1'b1;
         end
      end

      if (start || byp_load) begin
         x_in = req_sample_in;
      end else if (round_step) begin
         // section output feeds the next section, or waits for the output stage
         x_in = y_sat;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = x_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      b_vld_in = issue;
      b_tap_in = issue_tap;
      c_vld_in = b_vld_ff;
      c_neg_in = (b_tap_ff == TAP_A1) || (b_tap_ff == TAP_A2);
      prod_in  = b_vld_ff ? ACC_W'(mult_full) : prod_ff;
      if (acc_clr) begin
         acc_in = '0;
      end else if (c_vld_ff) begin
         acc_in = c_neg_ff ? acc_ff - prod_ff : acc_ff + prod_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gain_ff       <= GAIN_RESET;
         bypass_ff     <= 1'b0;
         coef_vld_ff   <= '0;
         hist_vld_ff   <= '0;
         coef_rvld_ff  <= 1'b0;
         hist_rvld_ff  <= 1'b0;
         coef_addr_ff  <= '0;
         sec_ff        <= '0;
         tap_ff        <= TAP_B0;
         gain_phase_ff <= 1'b0;
         b_vld_ff      <= 1'b0;
         b_tap_ff      <= TAP_B0;
         c_vld_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gain_ff       <= gain_in;
         bypass_ff     <= bypass_in;
         coef_vld_ff   <= coef_vld_in;
         hist_vld_ff   <= hist_vld_in;
         coef_rvld_ff  <= coef_rvld_in;
         hist_rvld_ff  <= hist_rvld_in;
         coef_addr_ff  <= coef_addr_in;
         sec_ff        <= sec_in;
         tap_ff        <= tap_in;
         gain_phase_ff <= gain_phase_in;
         b_vld_ff      <= b_vld_in;
         b_tap_ff      <= b_tap_in;
         c_vld_ff      <= c_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_neg_ff    <= c_neg_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      hx1_ff      <= hx1_in;
      hx2_ff      <= hx2_in;
      hy1_ff      <= hy1_in;
      hy2_ff      <= hy2_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

[rtl/core/bqeq_checker.sv]
// Port-level checker for the biquad equalizer, bound to the top level below.
// Depends on bqeq_pkg and four_section_biquad_equalizer_defines.svh.
`include "four_section_biquad_equalizer_defines.svh"

module bqeq_checker #(
   parameter int SAMPLE_WIDTH = bqeq_pkg::SAMPLE_WIDTH_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [bqeq_pkg::OPCODE_W-1:0]     req_opcode,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0]    rsp_sample_out
);
   import bqeq_pkg::*;

   // a stalled response holds its value
   `BQEQ_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out),
      "response dropped or changed while stalled")

   // a filter request always leaves the block busy in the cycle after it is accepted
   `BQEQ_ASSERT(a_filter_busy, clock, reset,
      req_valid && req_ready && req_opcode == OP_FILTER |=> !req_ready,
      "block ready right after accepting a filter request")

   // coefficient writes and clears finish in the cycle they are accepted
   `BQEQ_ASSERT(a_ctrl_oneshot, clock, reset,
      req_valid && req_ready && (req_opcode == OP_COEF_WRITE || req_opcode == OP_CLEAR)
      |=> req_ready,
      "block busy after a coefficient write or clear")

   // reset leaves the block idle with no response pending
   `BQEQ_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> req_ready && !rsp_valid,
      "block not idle after reset")

endmodule

bind four_section_biquad_equalizer bqeq_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bqeq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_opcode     (req_opcode),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out)
);

[bench/tb_four_section_biquad_equalizer.sv]
// Self-checking bench for the four-section biquad equalizer: drives requests and CSR writes,
// predicts every output sample in-line and compares it with what the block returns.
// Depends on bqeq_pkg and the four_section_biquad_equalizer RTL.
`timescale 1ns / 100ps

module tb_four_section_biquad_equalizer;
   import bqeq_pkg::*;

   localparam int SECTIONS       = SECTIONS_DEF;
   localparam int SAMPLE_W       = SAMPLE_WIDTH_DEF;
   localparam int COEF_FRAC      = COEF_FRAC_BITS_DEF;
   localparam int NUM_COEFS      = TAPS * SECTIONS;
   localparam int NUM_HIST       = HIST_PER_SEC * SECTIONS;
   localparam int SETTLE_CYCLES  = 48;
   localparam int REQUEST_TARGET = 1575;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh80_0000;
   localparam logic signed [COEF_W-1:0]   COEF_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [COEF_W-1:0]   COEF_MIN   = 32'sh8000_0000;
   localparam logic signed [COEF_W-1:0]   UNITY_COEF = 32'sd134217728;
   localparam logic [GAIN_W-1:0]          GAIN_LOW   = 16'd4115;
   localparam logic [GAIN_W-1:0]          GAIN_HIGH  = 16'd65273;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [OPCODE_W-1:0]         req_opcode = OP_FILTER;
   logic signed [SAMPLE_W-1:0]  req_sample_in = '0;
   logic [COEF_IDX_W-1:0]       req_coef_index = '0;
   logic signed [COEF_W-1:0]    req_coef_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]  rsp_sample_out;
   logic                        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = CSR_MASTER_GAIN;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   // Equalizer state as the bench sees it
   logic signed [COEF_W-1:0]    coef_bank [NUM_COEFS];
   logic signed [SAMPLE_W-1:0]  sample_hist [NUM_HIST];  // x1, x2, y1, y2 per section
   logic [GAIN_W-1:0]           gain_q14 = GAIN_RESET;
   logic                        bypass_on = 1'b0;

   logic signed [SAMPLE_W-1:0]  expected_samples [$];
   logic signed [SAMPLE_W-1:0]  due_sample;
   logic                        steady_flow = 1'b0;
   int                          mismatch_count = 0;
   int                          scored_requests = 0;

   four_section_biquad_equalizer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_sample_in  (req_sample_in),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      foreach (coef_bank[i]) coef_bank[i] = '0;
      foreach (sample_hist[i]) sample_hist[i] = '0;
   end

   function automatic longint round_half_up(longint acc, int frac);
      return (acc + (longint'(1) <<< (frac - 1))) >>> frac;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clamp_sample(longint v);
      if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
      if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
      return v[SAMPLE_W-1:0];
   endfunction

   // Update the bench copy of the state and queue the sample the block owes us.
   task automatic predict_request(input logic [OPCODE_W-1:0] op,
                                  input logic signed [SAMPLE_W-1:0] smp,
                                  input logic [COEF_IDX_W-1:0] idx,
                                  input logic signed [COEF_W-1:0] cv);
      longint acc;
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
      int base;
      int hb;
      case (op)
         OP_COEF_WRITE: begin
            if (idx < NUM_COEFS) begin
               coef_bank[idx] = cv;
               scored_requests++;
            end
         end
         OP_CLEAR: begin
            foreach (sample_hist[i]) sample_hist[i] = '0;
            scored_requests++;
         end
         OP_FILTER: begin
            scored_requests++;
            x = smp;
            if (!bypass_on) begin
               for (int s = 0; s < SECTIONS; s++) begin
                  base = s * TAPS;
                  hb   = s * HIST_PER_SEC;
                  acc = longint'(coef_bank[base + TAP_B0]) * longint'(x)
                      + longint'(coef_bank[base + TAP_B1]) * longint'(sample_hist[hb])
                      + longint'(coef_bank[base + TAP_B2]) * longint'(sample_hist[hb + 1])
                      - longint'(coef_bank[base + TAP_A1]) * longint'(sample_hist[hb + 2])
                      - longint'(coef_bank[base + TAP_A2]) * longint'(sample_hist[hb + 3]);
                  y = clamp_sample(round_half_up(acc, COEF_FRAC));
                  sample_hist[hb + 1] = sample_hist[hb];
                  sample_hist[hb]     = x;
                  sample_hist[hb + 3] = sample_hist[hb + 2];
                  sample_hist[hb + 2] = y;
                  x = y;
               end
               x = clamp_sample(round_half_up(longint'(x) * longint'(gain_q14), GAIN_FRAC_BITS));
            end
            expected_samples.push_back(x);
         end
         default: ;
      endcase
   endtask

   // Present one request, hold it until accepted, then predict.
   task automatic send_request(input logic [OPCODE_W-1:0] op,
                               input logic signed [SAMPLE_W-1:0] smp,
                               input logic [COEF_IDX_W-1:0] idx,
                               input logic signed [COEF_W-1:0] cv);
      while (!steady_flow && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_sample_in  <= smp;
      req_coef_index <= idx;
      req_coef_value <= cv;
      do @(posedge clock); while (!req_ready);
      predict_request(op, smp, idx, cv);
   endtask

   task automatic filter_sample(input logic signed [SAMPLE_W-1:0] smp);
      send_request(OP_FILTER, smp, COEF_IDX_W'($urandom), COEF_W'($urandom));
   endtask

   task automatic write_coefficient(input logic [COEF_IDX_W-1:0] idx,
                                    input logic signed [COEF_W-1:0] cv);
      send_request(OP_COEF_WRITE, SAMPLE_W'($urandom), idx, cv);
   endtask

   task automatic clear_history();
      send_request(OP_CLEAR, SAMPLE_W'($urandom), COEF_IDX_W'($urandom), COEF_W'($urandom));
   endtask

   // Drop valid and hold until every owed sample is back; optionally let the
   // datapath settle before touching the CSRs.
   task automatic wait_for_drain(input bit settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_samples.size() != 0);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_MASTER_GAIN) gain_q14 = data;
      else bypass_on = data[0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic signed [31:0] r;
      r = $urandom;
      r = r >>> $urandom_range(16, 8);
      return r[SAMPLE_W-1:0];
   endfunction

   // Mostly stable sections with gains near unity; a wild set is raw noise.
   task automatic load_coefficient_set(input bit wild);
      logic signed [COEF_W-1:0] taps [TAPS];
      int a1_bound;
      for (int s = 0; s < SECTIONS; s++) begin
         if (wild) begin
            foreach (taps[t]) taps[t] = $urandom;
         end else begin
            taps[TAP_B0] = 33_554_432 + $urandom_range(234_881_024, 0);
            taps[TAP_B1] = $urandom_range(536_870_912, 0) - 268_435_456;
            taps[TAP_B2] = $urandom_range(268_435_456, 0) - 134_217_728;
            taps[TAP_A2] = $urandom_range(187_000_000, 0) - 67_000_000;
            a1_bound = ((134_217_728 + int'(taps[TAP_A2])) / 10) * 9;
            taps[TAP_A1] = $urandom_range(2 * a1_bound, 0) - a1_bound;
         end
         for (int t = 0; t < TAPS; t++) write_coefficient(COEF_IDX_W'(s * TAPS + t), taps[t]);
      end
   endtask

   // Response side: random backpressure and in-order comparison.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample_out %0d, expected none", $time, rsp_sample_out);
               mismatch_count++;
            end else begin
               due_sample = expected_samples.pop_front();
               if (rsp_sample_out !== due_sample) begin
                  $display("%0t: sample_out expected %0d, got %0d",
                           $time, due_sample, rsp_sample_out);
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= steady_flow || ($urandom_range(99) >= 20);
      end
   end

   // All coefficients are zero out of reset, so the output must be silent.
   task automatic test_zero_coefficients();
      filter_sample(SAMPLE_MAX);
      filter_sample(SAMPLE_MIN);
      filter_sample('0);
      filter_sample(-24'sd1);
   endtask

   task automatic test_coefficient_edges();
      write_coefficient(COEF_IDX_W'(TAP_B0), COEF_MAX);
      write_coefficient(COEF_IDX_W'(TAP_A2), COEF_MIN);
      write_coefficient(COEF_IDX_W'(NUM_COEFS - 1), COEF_MAX);
      // indexes past the last section must be dropped
      write_coefficient(COEF_IDX_W'(NUM_COEFS), COEF_MAX);
      write_coefficient('1, COEF_MIN);
      send_request(OP_UNUSED, SAMPLE_MAX, '1, COEF_MAX);
      filter_sample(SAMPLE_MAX);
      filter_sample(SAMPLE_MIN);
      clear_history();
      filter_sample(24'sd4096);
   endtask

   task automatic test_bypass_and_gain();
      wait_for_drain(1'b1);
      write_register(CSR_BYPASS_MODE, 16'd1);
      filter_sample(SAMPLE_MAX);
      filter_sample(SAMPLE_MIN);
      wait_for_drain(1'b1);
      write_register(CSR_BYPASS_MODE, 16'd0);
      write_register(CSR_MASTER_GAIN, GAIN_HIGH);
      for (int s = 1; s < SECTIONS; s++) write_coefficient(COEF_IDX_W'(s * TAPS), UNITY_COEF);
      write_coefficient(COEF_IDX_W'(NUM_COEFS - 1), '0);
      filter_sample(SAMPLE_MAX);
      filter_sample(24'sd65536);
      wait_for_drain(1'b1);
      write_register(CSR_MASTER_GAIN, GAIN_LOW);
      filter_sample(SAMPLE_MIN);
      filter_sample(-24'sd65536);
   endtask

   // Pause the sender mid-stream until the pipeline is empty, then resume.
   task automatic test_drain_midstream();
      repeat (6) filter_sample(pick_sample());
      wait_for_drain(1'b0);
      repeat (6) filter_sample(pick_sample());
   endtask

   task automatic test_random_programs();
      int phase;
      int roll;
      logic [GAIN_W-1:0] gain;
      phase = 0;
      while (scored_requests < REQUEST_TARGET) begin
         wait_for_drain(1'b1);
         steady_flow <= (phase == 4);
         case (phase % 6)
            0: gain = GAIN_RESET;
            1: gain = GAIN_LOW;
            2: gain = GAIN_HIGH;
            3: gain = '0;
            4: gain = '1;
            default: gain = $urandom_range(65535, 0);
         endcase
         write_register(CSR_MASTER_GAIN, gain);
         write_register(CSR_BYPASS_MODE, {15'($urandom), phase % 5 == 3});
         load_coefficient_set(phase % 4 == 2);
         if ($urandom_range(1)) clear_history();
         repeat ($urandom_range(160, 80)) begin
            roll = $urandom_range(99);
            if (roll < 86) filter_sample(pick_sample());
            else if (roll < 91)
               write_coefficient(COEF_IDX_W'($urandom),
                                 $urandom_range(1) ? COEF_W'($urandom)
                                                   : $urandom_range(134_217_728, 0) - 67_108_864);
            else if (roll < 94) clear_history();
            else if (roll < 97)
               send_request(OP_UNUSED, pick_sample(), COEF_IDX_W'($urandom), COEF_W'($urandom));
            else filter_sample($urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN);
         end
         phase++;
      end
      steady_flow <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_zero_coefficients();
      test_coefficient_edges();
      test_bypass_and_gain();
      test_drain_midstream();
      test_random_programs();
      wait_for_drain(1'b1);
      if (mismatch_count == 0 && expected_samples.size() == 0)
         $display("** four_section_biquad_equalizer: PASSED **");
      else
         $display("** four_section_biquad_equalizer: FAILED **");
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #4_000_000;
      $display("%0t: timeout with %0d samples outstanding", $time, expected_samples.size());
      $display("** four_section_biquad_equalizer: FAILED **");
      $finish;
   end

endmodule
